### rtl/udiv64_pkg.sv
//------------------------------------------------------------------------------
// udiv64_pkg: shared definitions for the 64-bit unsigned divider
// Holds the port word width and the control word that travels with each
// transaction down the divider pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package udiv64_pkg;

	// Width of the operand and result fields on the channels.
	localparam int unsigned WORD_W = 64;

	// Control word carried alongside the data of each pipeline stage.
	typedef struct packed {
		logic valid;
		logic dbz;
	} stage_ctl_t;

endpackage : udiv64_pkg

`default_nettype wire

### rtl/udiv64_req_if.sv
//------------------------------------------------------------------------------
// udiv64_req_if: request channel of the divider
// Carries a dividend and a divisor under a valid/ready handshake.
//------------------------------------------------------------------------------
`default_nettype none

interface udiv64_req_if;

	logic                                valid;
	logic                                ready;
	logic [udiv64_pkg::WORD_W-1:0]       dividend;
	logic [udiv64_pkg::WORD_W-1:0]       divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);

endinterface : udiv64_req_if

`default_nettype wire

### rtl/udiv64_rsp_if.sv
//------------------------------------------------------------------------------
// udiv64_rsp_if: response channel of the divider
// Carries quotient, remainder and the divide-by-zero flag under valid/ready.
//------------------------------------------------------------------------------
`default_nettype none

interface udiv64_rsp_if;

	logic                                valid;
	logic                                ready;
	logic [udiv64_pkg::WORD_W-1:0]       quotient;
	logic [udiv64_pkg::WORD_W-1:0]       remainder;
	logic                                divide_by_zero;

	modport source (
		output valid, output quotient, output remainder, output divide_by_zero,
		input ready
	);
	modport sink (
		input valid, input quotient, input remainder, input divide_by_zero,
		output ready
	);

endinterface : udiv64_rsp_if

`default_nettype wire

### rtl/udiv64_stage.sv
//------------------------------------------------------------------------------
// udiv64_stage: one restoring-division step with its pipeline register
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when that does not borrow, and shifts the quotient bit in at the
// bottom of the combined dividend/quotient word.
//------------------------------------------------------------------------------
`default_nettype none

module udiv64_stage #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  udiv64_pkg::stage_ctl_t       ctl_in,
	input  wire [DATA_WIDTH-1:0]         rem_in,
	input  wire [DATA_WIDTH-1:0]         nq_in,
	input  wire [DATA_WIDTH-1:0]         den_in,
	output udiv64_pkg::stage_ctl_t       ctl_out,
	output logic [DATA_WIDTH-1:0]        rem_out,
	output logic [DATA_WIDTH-1:0]        nq_out,
	output logic [DATA_WIDTH-1:0]        den_out
);

	udiv64_pkg::stage_ctl_t      ctl_s1;
	logic [DATA_WIDTH-1:0]       rem_s1;
	logic [DATA_WIDTH-1:0]       nq_s1;
	logic [DATA_WIDTH-1:0]       den_s1;

	logic [DATA_WIDTH:0]         shifted;
	logic [DATA_WIDTH:0]         diff;
	logic                        qbit;

	// The shifted remainder keeps its carry-out as an extra top bit, so the
	// compare is exact even for divisors with the top bit set.
	assign shifted = {rem_in, nq_in[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, den_in};
	assign qbit    = ~diff[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			nq_s1  <= {nq_in[DATA_WIDTH-2:0], qbit};
			den_s1 <= den_in;
		end
	end

	assign ctl_out = ctl_s1;
	assign rem_out = rem_s1;
	assign nq_out  = nq_s1;
	assign den_out = den_s1;

endmodule : udiv64_stage

`default_nettype wire

### rtl/unsigned_divide_64.sv
//------------------------------------------------------------------------------
// unsigned_divide_64: pipelined unsigned restoring divider
// Returns quotient, remainder and a divide-by-zero flag for each request.
//------------------------------------------------------------------------------
// The divider accepts one transaction per clock cycle while no finished result
// is held at the output, and passes it through one pipeline stage per quotient
// bit, each stage a single (DATA_WIDTH+1)-bit subtract. Operand bits at and
// above DATA_WIDTH are ignored and result bits above it read as zero. A zero
// divisor gives a quotient and remainder of zero with divide_by_zero set. The
// whole pipeline holds while a finished result waits at the output, so
// back-pressure never drops or duplicates a transaction; bubbles move forward
// whenever the output register is empty.
`default_nettype none

module unsigned_divide_64 #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	udiv64_req_if.sink           req,
	udiv64_rsp_if.source         rsp
);

	udiv64_pkg::stage_ctl_t      ctl  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0]       rem  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0]       nq   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0]       den  [0:DATA_WIDTH];

	logic                        adv;
	logic [udiv64_pkg::WORD_W-1:0] quo_ext;
	logic [udiv64_pkg::WORD_W-1:0] rem_ext;

	// The last stage register doubles as the output register.
	assign adv       = ~ctl[DATA_WIDTH].valid | rsp.ready;
	assign req.ready = adv;

	assign ctl[0].valid = req.valid;
	assign ctl[0].dbz   = (req.divisor[DATA_WIDTH-1:0] == '0);
	assign rem[0]       = '0;
	assign nq[0]        = req.dividend[DATA_WIDTH-1:0];
	assign den[0]       = req.divisor[DATA_WIDTH-1:0];

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
		udiv64_stage #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.ctl_in  (ctl[i]),
			.rem_in  (rem[i]),
			.nq_in   (nq[i]),
			.den_in  (den[i]),
			.ctl_out (ctl[i+1]),
			.rem_out (rem[i+1]),
			.nq_out  (nq[i+1]),
			.den_out (den[i+1])
		);
	end

	assign quo_ext = udiv64_pkg::WORD_W'(nq[DATA_WIDTH]);
	assign rem_ext = udiv64_pkg::WORD_W'(rem[DATA_WIDTH]);

	assign rsp.valid          = ctl[DATA_WIDTH].valid;
	assign rsp.divide_by_zero = ctl[DATA_WIDTH].dbz;
	assign rsp.quotient       = ctl[DATA_WIDTH].dbz ? '0 : quo_ext;
	assign rsp.remainder      = ctl[DATA_WIDTH].dbz ? '0 : rem_ext;

endmodule : unsigned_divide_64

`default_nettype wire

### tb/tb.sv
//------------------------------------------------------------------------------
// tb: self-checking testbench for unsigned_divide_64
// Drives dividend/divisor pairs into the request channel and checks every
// response against a restoring-division predictor. The run covers directed
// edge cases, random traffic with idle gaps on both sides, a back-to-back
// stream, and a long output hold that fills the pipeline.
//------------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DW          = 64;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef logic [udiv64_pkg::WORD_W-1:0] word_t;

	typedef struct packed {
		word_t quotient;
		word_t remainder;
		logic  divide_by_zero;
	} div_result_t;

	logic clk;
	logic arst_n;

	udiv64_req_if req_ch ();
	udiv64_rsp_if rsp_ch ();

	unsigned_divide_64 #(
		.DATA_WIDTH(DW)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	div_result_t pending_results[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          src_gaps_on;
	bit          sink_stalls_on;
	int unsigned hold_requests;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Restoring division with a partial remainder one bit wider than the operands.
	function automatic div_result_t predict_division(input word_t num_in, input word_t den_in);
		div_result_t res;
		word_t       mask;
		word_t       num;
		word_t       den;
		logic [DW:0] part;
		mask = (DW == udiv64_pkg::WORD_W) ? '1 : ((word_t'(1) << DW) - 1);
		num  = num_in & mask;
		den  = den_in & mask;
		res  = '0;
		part = '0;
		if (den == '0) begin
			res.divide_by_zero = 1'b1;
			return res;
		end
		for (int k = DW - 1; k >= 0; k--) begin
			part = {part[DW-1:0], num[k]};
			if (part >= {1'b0, den[DW-1:0]}) begin
				part = part - {1'b0, den[DW-1:0]};
				res.quotient[k] = 1'b1;
			end
		end
		res.remainder = word_t'(part[DW-1:0]);
		return res;
	endfunction

	function automatic int unsigned idle_length();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 3);
	endfunction

	function automatic word_t random_word();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string field, input word_t got, input word_t want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %h, predicted %h", $realtime, field, got, want);
	endtask

	// Receiver: random stalls, plus a long hold whenever a test asks for one.
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned holds_served;
		stall_left   = 0;
		hold_left    = 0;
		holds_served = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready = 1'b0;
			end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
				stall_left   = idle_length() - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// Each accepted response is matched against the oldest prediction.
	always @(posedge clk) begin
		div_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction (quotient)", rsp_ch.quotient, '0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.quotient !== want.quotient)
					report_mismatch("quotient", rsp_ch.quotient, want.quotient);
				if (rsp_ch.remainder !== want.remainder)
					report_mismatch("remainder", rsp_ch.remainder, want.remainder);
				if (rsp_ch.divide_by_zero !== want.divide_by_zero)
					report_mismatch("divide_by_zero", word_t'(rsp_ch.divide_by_zero),
						word_t'(want.divide_by_zero));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_division(input word_t dividend, input word_t divisor);
		int unsigned gap;
		gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid    = 1'b0;
			req_ch.dividend = random_word();
			req_ch.divisor  = random_word();
			repeat (gap) @(negedge clk);
		end
		req_ch.valid    = 1'b1;
		req_ch.dividend = dividend;
		req_ch.divisor  = divisor;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_division(dividend, divisor));
	endtask

	task automatic release_source();
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	// Operand pairs spread over all magnitudes, so quotients of every length occur.
	task automatic random_operands(output word_t dividend, output word_t divisor);
		word_t q;
		word_t r;
		case ($urandom_range(0, 9))
			0: begin
				dividend = random_word();
				divisor  = '0;
			end
			1: begin
				dividend = random_word();
				divisor  = random_word();
			end
			2: begin
				divisor  = random_word() >> $urandom_range(0, 63);
				dividend = divisor - word_t'($urandom_range(0, 3));
			end
			3: begin
				dividend = random_word();
				divisor  = ($urandom_range(0, 1) == 0) ? word_t'(1) : dividend;
			end
			4, 5: begin
				divisor  = (random_word() >> $urandom_range(0, 63)) | word_t'(1);
				q        = random_word() >> $urandom_range(0, 63);
				r        = random_word() % divisor;
				dividend = q * divisor + r;
			end
			default: begin
				dividend = random_word() >> $urandom_range(0, 63);
				divisor  = random_word() >> $urandom_range(0, 63);
			end
		endcase
	endtask

	task automatic test_directed();
		word_t max_w;
		word_t top_bit;
		max_w   = '1;
		top_bit = word_t'(1) << (udiv64_pkg::WORD_W - 1);
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		send_division('0, '0);
		send_division(max_w, '0);
		send_division(word_t'(12345), '0);
		send_division('0, word_t'(1));
		send_division(max_w, word_t'(1));
		send_division(max_w, max_w);
		send_division(word_t'(1), max_w);
		send_division(max_w - 1, max_w);
		send_division(max_w, max_w - 1);
		send_division('0, max_w);
		send_division(max_w, top_bit);
		send_division(top_bit, top_bit + 1);
		send_division(top_bit, word_t'(1));
		send_division(word_t'(5), word_t'(7));
		send_division(word_t'(100), word_t'(7));
		send_division(max_w, word_t'(3));
		send_division(word_t'(1), word_t'(1));
		send_division(top_bit - 1, top_bit);
		send_division(max_w, word_t'(2));
		send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_division(64'hFEDC_BA98_7654_3210, 64'h0000_0001_0000_0000);
		release_source();
	endtask

	task automatic test_random_divisions(input int unsigned count);
		word_t a;
		word_t b;
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		for (int unsigned i = 0; i < count; i++) begin
			random_operands(a, b);
			send_division(a, b);
		end
		release_source();
	endtask

	task automatic test_back_to_back(input int unsigned count);
		word_t a;
		word_t b;
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		for (int unsigned i = 0; i < count; i++) begin
			random_operands(a, b);
			send_division(a, b);
		end
		release_source();
	endtask

	// The receiver holds off while the sender keeps offering, so the pipeline
	// fills and must stall its request channel without losing a transaction.
	task automatic test_output_hold(input int unsigned count);
		word_t a;
		word_t b;
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		@(negedge clk);
		hold_requests++;
		for (int unsigned i = 0; i < count; i++) begin
			random_operands(a, b);
			send_division(a, b);
		end
		release_source();
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.dividend = '0;
		req_ch.divisor  = '0;
		mismatch_count  = 0;
		cycle_count     = 0;
		hold_requests   = 0;
		src_gaps_on     = 1'b0;
		sink_stalls_on  = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_divisions(750);
		test_back_to_back(100);
		test_output_hold(200);
		test_random_divisions(100);

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DW + 16) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule : tb
